// ----- rtl/core/qrv_pkg.sv -----
// Shared types, widths and rounding helpers for the quaternion vector rotator.
// Depends on nothing; imported by qrv_stage1 and quaternion_rotate_vector_top.
package qrv_pkg;

    // Fraction bits of the quaternion components and of the rounding shift
    localparam int FRAC_BITS = 15;

    localparam int IN_W    = 16;
    localparam int OUT_W   = 16;
    localparam int T_W     = 18;
    localparam int PROD1_W = 2 * IN_W;
    localparam int SUM1_W  = PROD1_W + 2;
    localparam int PROD2_W = T_W + IN_W;
    localparam int SUM2_W  = PROD2_W + 2;

    typedef logic signed [IN_W-1:0]    comp_t;
    typedef logic signed [T_W-1:0]     term_t;
    typedef logic signed [PROD1_W-1:0] prod1_t;
    typedef logic signed [SUM1_W-1:0]  sum1_t;
    typedef logic signed [PROD2_W-1:0] prod2_t;
    typedef logic signed [SUM2_W-1:0]  sum2_t;

    typedef struct packed {
        comp_t x;
        comp_t y;
        comp_t z;
        comp_t w;
    } quat_t;

    // Control carried alongside each pipeline stage
    typedef struct packed {
        logic valid;
        logic clip;
    } ctl_t;

    typedef struct packed {
        term_t val;
        logic  clip;
    } term_res_t;

    typedef struct packed {
        comp_t val;
        logic  clip;
    } out_res_t;

    localparam sum1_t RND1   = sum1_t'(1) <<< (FRAC_BITS - 1);
    localparam sum1_t T_MAX1 = sum1_t'(2 ** (T_W - 1) - 1);
    localparam sum1_t T_MIN1 = sum1_t'(-(2 ** (T_W - 1)));

    localparam sum2_t RND2   = sum2_t'(1) <<< (FRAC_BITS - 1);
    localparam sum2_t O_MAX2 = sum2_t'(2 ** (OUT_W - 1) - 1);
    localparam sum2_t O_MIN2 = sum2_t'(-(2 ** (OUT_W - 1)));

    localparam comp_t O_MAX = comp_t'(2 ** (OUT_W - 1) - 1);
    localparam comp_t O_MIN = comp_t'(-(2 ** (OUT_W - 1)));
    localparam term_t T_MAX = term_t'(2 ** (T_W - 1) - 1);
    localparam term_t T_MIN = term_t'(-(2 ** (T_W - 1)));

    // Round to nearest (ties up) and saturate to the intermediate term width
    function automatic term_res_t round_sat_term(input sum1_t s);
        sum1_t     a;
        term_res_t r;
        a = (s + RND1) >>> FRAC_BITS;
        if (a > T_MAX1)
        begin
            r.val  = T_MAX;
            r.clip = 1'b1;
        end
        else if (a < T_MIN1)
        begin
            r.val  = T_MIN;
            r.clip = 1'b1;
        end
        else
        begin
            r.val  = a[T_W-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

    // Round to nearest (ties up) and saturate to the output width
    function automatic out_res_t round_sat_out(input sum2_t s);
        sum2_t    a;
        out_res_t r;
        a = (s + RND2) >>> FRAC_BITS;
        if (a > O_MAX2)
        begin
            r.val  = O_MAX;
            r.clip = 1'b1;
        end
        else if (a < O_MIN2)
        begin
            r.val  = O_MIN;
            r.clip = 1'b1;
        end
        else
        begin
            r.val  = a[OUT_W-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/qrv_stage1.sv -----
// First product stage t = q * (v, 0): one multiplier row, then one sum/round row.
// Depends on qrv_pkg.
module qrv_stage1
    import qrv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  quat_t q_in,
    input  comp_t vx,
    input  comp_t vy,
    input  comp_t vz,
    output ctl_t  t_ctl,
    output term_t t_x,
    output term_t t_y,
    output term_t t_z,
    output term_t t_w,
    output quat_t q_out
);

    prod1_t p_reg  [12];
    prod1_t p_next [12];
    quat_t  qa_reg;
    logic   va_reg;

    term_t  tx_reg, ty_reg, tz_reg, tw_reg;
    quat_t  qb_reg;
    ctl_t   tc_reg;
    ctl_t   tc_next;
    term_res_t rx, ry, rz, rw;

    // Form the twelve partial products
    always_comb
    begin
        p_next[0]  = q_in.w * vx;
        p_next[1]  = q_in.y * vz;
        p_next[2]  = q_in.z * vy;
        p_next[3]  = q_in.w * vy;
        p_next[4]  = q_in.z * vx;
        p_next[5]  = q_in.x * vz;
        p_next[6]  = q_in.w * vz;
        p_next[7]  = q_in.x * vy;
        p_next[8]  = q_in.y * vx;
        p_next[9]  = q_in.x * vx;
        p_next[10] = q_in.y * vy;
        p_next[11] = q_in.z * vz;
    end

    // Sum, round and saturate each term
    always_comb
    begin
        rx = round_sat_term(sum1_t'(p_reg[0]) + sum1_t'(p_reg[1]) - sum1_t'(p_reg[2]));
        ry = round_sat_term(sum1_t'(p_reg[3]) + sum1_t'(p_reg[4]) - sum1_t'(p_reg[5]));
        rz = round_sat_term(sum1_t'(p_reg[6]) + sum1_t'(p_reg[7]) - sum1_t'(p_reg[8]));
        rw = round_sat_term(sum1_t'(p_reg[9]) + sum1_t'(p_reg[10]) + sum1_t'(p_reg[11]));
        tc_next.valid = va_reg;
        tc_next.clip  = rx.clip | ry.clip | rz.clip | rw.clip;
    end

    // Advance valid bits and clip flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            tc_reg <= '0;
        end
        else
        begin
            va_reg <= in_valid;
            tc_reg <= tc_next;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 12; i++)
        begin
            p_reg[i] <= p_next[i];
        end
        qa_reg      <= q_in;
        qb_reg      <= qa_reg;
        tx_reg      <= rx.val;
        ty_reg      <= ry.val;
        tz_reg      <= rz.val;
        tw_reg      <= rw.val;
    end

    assign t_ctl = tc_reg;
    assign t_x   = tx_reg;
    assign t_y   = ty_reg;
    assign t_z   = tz_reg;
    assign t_w   = tw_reg;
    assign q_out = qb_reg;

`ifndef SYNTH
    a_t_latency : assert property (@(posedge clk) disable iff (!rst_n)
        t_ctl.valid |-> $past(in_valid, 2))
        else $error("stage one term without a request two cycles earlier");

    a_t_follows : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##2 t_ctl.valid)
        else $error("request did not reach stage one output two cycles later");

    a_t_clip : assert property (@(posedge clk) disable iff (!rst_n)
        t_ctl.valid && t_ctl.clip |->
            (t_x == T_MAX || t_x == T_MIN || t_y == T_MAX || t_y == T_MIN ||
             t_z == T_MAX || t_z == T_MIN || t_w == T_MAX || t_w == T_MIN))
        else $error("stage one clip flagged with no term at a limit");
`endif

endmodule

// ----- rtl/core/quaternion_rotate_vector_top.sv -----
// Top level of the quaternion vector rotator: r = q * v * conj(q), saturated.
// Depends on qrv_pkg and qrv_stage1.
//
//  channel   direction  handshake                 payload
//  request   in         start (taken when !busy)  quat_x/y/z/w, vec_x/y/z
//  result    out        done, one-cycle strobe    rot_x/y/z, clipped
//
// One request is taken every cycle; each result passes through four register
// stages: multiplier row, sum/round row for t = q*v, multiplier row, sum/round
// row for t*conj(q). busy is always low. Reset clears the valid bits and their
// clip flags only; payload registers are not reset. The receiver cannot stall,
// so nothing is ever held back.
module quaternion_rotate_vector_top
    import qrv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  comp_t quat_x,
    input  comp_t quat_y,
    input  comp_t quat_z,
    input  comp_t quat_w,
    input  comp_t vec_x,
    input  comp_t vec_y,
    input  comp_t vec_z,
    output logic  done,
    output comp_t rot_x,
    output comp_t rot_y,
    output comp_t rot_z,
    output logic  clipped
);

    quat_t  q_in;
    quat_t  q2;
    ctl_t   t_ctl;
    term_t  t_x, t_y, t_z, t_w;

    prod2_t p_reg  [12];
    prod2_t p_next [12];
    ctl_t   s3_ctl_reg;

    comp_t  rx_reg, ry_reg, rz_reg;
    logic   clip_reg, clip_next;
    logic   done_reg;
    out_res_t ox, oy, oz;

    assign q_in.x = quat_x;
    assign q_in.y = quat_y;
    assign q_in.z = quat_z;
    assign q_in.w = quat_w;

    // The pipeline never stalls
    assign busy = 1'b0;

    qrv_stage1 u_stage1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .q_in     (q_in),
        .vx       (vec_x),
        .vy       (vec_y),
        .vz       (vec_z),
        .t_ctl    (t_ctl),
        .t_x      (t_x),
        .t_y      (t_y),
        .t_z      (t_z),
        .t_w      (t_w),
        .q_out    (q2)
    );

    // Form the twelve partial products of t * conj(q)
    always_comb
    begin
        p_next[0]  = t_w * q2.x;
        p_next[1]  = t_x * q2.w;
        p_next[2]  = t_y * q2.z;
        p_next[3]  = t_z * q2.y;
        p_next[4]  = t_w * q2.y;
        p_next[5]  = t_y * q2.w;
        p_next[6]  = t_z * q2.x;
        p_next[7]  = t_x * q2.z;
        p_next[8]  = t_w * q2.z;
        p_next[9]  = t_z * q2.w;
        p_next[10] = t_x * q2.y;
        p_next[11] = t_y * q2.x;
    end

    // Sum, round and saturate each output component
    always_comb
    begin
        ox = round_sat_out(sum2_t'(p_reg[0]) + sum2_t'(p_reg[1])
                         - sum2_t'(p_reg[2]) + sum2_t'(p_reg[3]));
        oy = round_sat_out(sum2_t'(p_reg[4]) + sum2_t'(p_reg[5])
                         - sum2_t'(p_reg[6]) + sum2_t'(p_reg[7]));
        oz = round_sat_out(sum2_t'(p_reg[8]) + sum2_t'(p_reg[9])
                         - sum2_t'(p_reg[10]) + sum2_t'(p_reg[11]));
        clip_next = s3_ctl_reg.clip | ox.clip | oy.clip | oz.clip;
    end

    // Advance valid bits and clip flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_ctl_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s3_ctl_reg <= t_ctl;
            done_reg   <= s3_ctl_reg.valid;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 12; i++)
        begin
            p_reg[i] <= p_next[i];
        end
        rx_reg          <= ox.val;
        ry_reg          <= oy.val;
        rz_reg          <= oz.val;
        clip_reg        <= clip_next;
    end

    assign done    = done_reg;
    assign rot_x   = rx_reg;
    assign rot_y   = ry_reg;
    assign rot_z   = rz_reg;
    assign clipped = clip_reg;

`ifndef SYNTH
    a_latency_fwd : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##4 done)
        else $error("request did not produce a result four cycles later");

    a_latency_back : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 4))
        else $error("result strobe without a matching request");

    a_out_clip : assert property (@(posedge clk) disable iff (!rst_n)
        done && clipped && !$past(s3_ctl_reg.clip) |->
            (rot_x == O_MAX || rot_x == O_MIN || rot_y == O_MAX || rot_y == O_MIN ||
             rot_z == O_MAX || rot_z == O_MIN))
        else $error("output clip flagged with no component at a limit");
`endif

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for quaternion_rotate_vector_top: directed table, then random requests.
// Each result is checked field by field against its typed table row or a fixed-point prediction.
// Depends on qrv_pkg and the RTL under rtl/core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import qrv_pkg::*;

    typedef struct packed {
        comp_t qx;
        comp_t qy;
        comp_t qz;
        comp_t qw;
        comp_t vx;
        comp_t vy;
        comp_t vz;
    } rot_request_t;

    typedef struct packed {
        comp_t x;
        comp_t y;
        comp_t z;
        logic  clip;
    } rot_vector_t;

    typedef struct {
        rot_request_t req;
        bit           typed;
        rot_vector_t  res;
    } directed_row_t;

    localparam int RANDOM_REQUESTS = 1730;
    localparam int DRAIN_EVERY     = 500;

    logic  clk     = 1'b0;
    logic  rst_n   = 1'b0;
    logic  start   = 1'b0;
    comp_t quat_x  = '0;
    comp_t quat_y  = '0;
    comp_t quat_z  = '0;
    comp_t quat_w  = '0;
    comp_t vec_x   = '0;
    comp_t vec_y   = '0;
    comp_t vec_z   = '0;
    logic  busy;
    logic  done;
    comp_t rot_x;
    comp_t rot_y;
    comp_t rot_z;
    logic  clipped;

    rot_vector_t   pending_rotations[$];
    directed_row_t directed_rows[$];
    int            mismatches = 0;
    int            burst_left = 0;

    quaternion_rotate_vector_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .quat_x  (quat_x),
        .quat_y  (quat_y),
        .quat_z  (quat_z),
        .quat_w  (quat_w),
        .vec_x   (vec_x),
        .vec_y   (vec_y),
        .vec_z   (vec_z),
        .done    (done),
        .rot_x   (rot_x),
        .rot_y   (rot_y),
        .rot_z   (rot_z),
        .clipped (clipped)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case results stop arriving
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Round to nearest with ties towards plus infinity, floor shift
    function automatic longint round_frac(input longint s);
        return (s + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi,
                                     inout logic clip);
        if (v > hi)
        begin
            clip = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            clip = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // Rotate v by q: t = q * (v, 0), then r = (t * conj(q)).xyz, both stages rounded
    function automatic rot_vector_t rotate_by_quat(input rot_request_t r);
        longint      qx, qy, qz, qw, vx, vy, vz;
        longint      tx, ty, tz, tw, tlo, thi, olo, ohi;
        logic        clip;
        rot_vector_t res;
        qx   = r.qx;
        qy   = r.qy;
        qz   = r.qz;
        qw   = r.qw;
        vx   = r.vx;
        vy   = r.vy;
        vz   = r.vz;
        tlo  = T_MIN;
        thi  = T_MAX;
        olo  = O_MIN;
        ohi  = O_MAX;
        clip = 1'b0;
        tx = clamp(round_frac(qw * vx + qy * vz - qz * vy), tlo, thi, clip);
        ty = clamp(round_frac(qw * vy + qz * vx - qx * vz), tlo, thi, clip);
        tz = clamp(round_frac(qw * vz + qx * vy - qy * vx), tlo, thi, clip);
        tw = clamp(round_frac(qx * vx + qy * vy + qz * vz), tlo, thi, clip);
        res.x = comp_t'(clamp(round_frac(tw * qx + tx * qw - ty * qz + tz * qy), olo, ohi, clip));
        res.y = comp_t'(clamp(round_frac(tw * qy + ty * qw - tz * qx + tx * qz), olo, ohi, clip));
        res.z = comp_t'(clamp(round_frac(tw * qz + tz * qw - tx * qy + ty * qx), olo, ohi, clip));
        res.clip = clip;
        return res;
    endfunction

    function automatic comp_t extreme_comp();
        case ($urandom_range(0, 6))
            0:       return comp_t'(-32768);
            1:       return comp_t'(-32767);
            2:       return comp_t'(-1);
            3:       return comp_t'(0);
            4:       return comp_t'(1);
            5:       return comp_t'(16384);
            default: return comp_t'(32767);
        endcase
    endfunction

    // Half full range, half small magnitudes
    function automatic comp_t random_vec_comp();
        if ($urandom_range(0, 1) == 1)
            return comp_t'($urandom);
        return comp_t'($urandom_range(0, 2047) - 1024);
    endfunction

    function automatic rot_request_t random_request();
        rot_request_t r;
        real          c[4];
        real          n;
        int           kind;
        kind = $urandom_range(0, 9);
        r.vx = random_vec_comp();
        r.vy = random_vec_comp();
        r.vz = random_vec_comp();
        if (kind <= 5)
        begin
            // Normalised quaternion: the well-formed case, mostly unclipped
            n = 0.0;
            for (int k = 0; k < 4; k++)
            begin
                c[k] = ($urandom_range(0, 65535) - 32768.0) / 32768.0;
                n += c[k] * c[k];
            end
            n = $sqrt(n);
            if (n < 0.001)
            begin
                c[0] = 0.0;
                c[1] = 0.0;
                c[2] = 0.0;
                c[3] = 1.0;
                n    = 1.0;
            end
            r.qx = comp_t'($rtoi(c[0] / n * 32767.0));
            r.qy = comp_t'($rtoi(c[1] / n * 32767.0));
            r.qz = comp_t'($rtoi(c[2] / n * 32767.0));
            r.qw = comp_t'($rtoi(c[3] / n * 32767.0));
        end
        else if (kind <= 7)
        begin
            // Raw bits everywhere
            r.qx = comp_t'($urandom);
            r.qy = comp_t'($urandom);
            r.qz = comp_t'($urandom);
            r.qw = comp_t'($urandom);
            r.vx = comp_t'($urandom);
            r.vy = comp_t'($urandom);
            r.vz = comp_t'($urandom);
        end
        else if (kind == 8)
        begin
            r.qx = extreme_comp();
            r.qy = extreme_comp();
            r.qz = extreme_comp();
            r.qw = extreme_comp();
            r.vx = extreme_comp();
            r.vy = extreme_comp();
            r.vz = extreme_comp();
        end
        else
        begin
            // Half turn or near-identity about a single axis
            r.qx = '0;
            r.qy = '0;
            r.qz = '0;
            r.qw = '0;
            case ($urandom_range(0, 3))
                0:       r.qx = $urandom_range(0, 1) ? comp_t'(-32768) : comp_t'(32767);
                1:       r.qy = $urandom_range(0, 1) ? comp_t'(-32768) : comp_t'(32767);
                2:       r.qz = $urandom_range(0, 1) ? comp_t'(-32768) : comp_t'(32767);
                default: r.qw = $urandom_range(0, 1) ? comp_t'(-32768) : comp_t'(32767);
            endcase
        end
        return r;
    endfunction

    task automatic add_row(input int qx, input int qy, input int qz, input int qw,
                           input int vx, input int vy, input int vz, input bit typed,
                           input int rx, input int ry, input int rz, input bit clip);
        directed_row_t row;
        row.req   = '{comp_t'(qx), comp_t'(qy), comp_t'(qz), comp_t'(qw),
                      comp_t'(vx), comp_t'(vy), comp_t'(vz)};
        row.typed = typed;
        row.res   = '{comp_t'(rx), comp_t'(ry), comp_t'(rz), clip};
        directed_rows.push_back(row);
    endtask

    // Hold the request on the ports until it is taken, then log its expected result
    task automatic send_rotation(input rot_request_t r, input rot_vector_t want);
        start  <= 1'b1;
        quat_x <= r.qx;
        quat_y <= r.qy;
        quat_z <= r.qz;
        quat_w <= r.qw;
        vec_x  <= r.vx;
        vec_y  <= r.vy;
        vec_z  <= r.vz;
        do
            @(posedge clk);
        while (busy);
        pending_rotations.push_back(want);
    endtask

    // Bursts of random length separated by random gaps
    task automatic pace_sender();
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
    endtask

    // Hold off until every outstanding result has come back
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_rotations.size() != 0);
    endtask

    // Check each result strobe against the oldest expectation
    always @(posedge clk)
    begin : check_results
        rot_vector_t want;
        if (rst_n && done)
        begin
            if (pending_rotations.size() == 0)
            begin
                report_mismatch("result strobe with no request outstanding");
            end
            else
            begin
                want = pending_rotations.pop_front();
                if (rot_x !== want.x)
                    report_mismatch($sformatf("rot_x got %0d want %0d", rot_x, want.x));
                if (rot_y !== want.y)
                    report_mismatch($sformatf("rot_y got %0d want %0d", rot_y, want.y));
                if (rot_z !== want.z)
                    report_mismatch($sformatf("rot_z got %0d want %0d", rot_z, want.z));
                if (clipped !== want.clip)
                    report_mismatch($sformatf("clipped got %b want %b", clipped, want.clip));
            end
        end
    end

    initial
    begin : stimulus
        rot_request_t req;
        rot_vector_t  want;

        //        qx      qy      qz      qw      vx      vy      vz  typed  rx  ry  rz  clip
        // Zero quaternion wipes the vector
        add_row(     0,      0,      0,      0,  32767, -32768,      1, 1,
                     0,      0,      0, 0);
        // Scalar part of exactly -1 gives the vector back unchanged
        add_row(     0,      0,      0, -32768,  32767, -32768,      1, 1,
                 32767, -32768,      1, 0);
        add_row(     0,      0,      0, -32768,      0,      0,      0, 1,
                     0,      0,      0, 0);
        // Half turns about each axis; negating -32768 saturates
        add_row(-32768,      0,      0,      0,    100, -32768,      5, 1,
                   100,  32767,     -5, 1);
        add_row(     0, -32768,      0,      0, -32768,      7,     -9, 1,
                 32767,      7,      9, 1);
        add_row(     0,      0, -32768,      0,      3,     -4, -32768, 1,
                    -3,      4, -32768, 0);
        // Non-unit extremes
        add_row( 32767,  32767,  32767,  32767,  32767,  32767,  32767, 0, 0, 0, 0, 0);
        add_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, 0, 0, 0, 0, 0);
        add_row( 32767,  32767,  32767,  32767, -32768,  32767, -32768, 0, 0, 0, 0, 0);
        add_row(    -1,     -1,     -1,     -1,     -1,     -1,     -1, 0, 0, 0, 0, 0);
        add_row(     1,      1,      1,      1,  32767,  32767,  32767, 0, 0, 0, 0, 0);
        // Near identity
        add_row(     0,      0,      0,  32767,  32767, -32768,     -1, 0, 0, 0, 0, 0);
        // Halves land exactly on rounding ties, positive and negative
        add_row(     0,      0,      0,  16384,      1,     -1,      3, 0, 0, 0, 0, 0);
        add_row(     0,      0,      0,  16384,     -3,     -1,      1, 0, 0, 0, 0, 0);
        // Quarter turns, and a third of a turn about the diagonal
        add_row(     0,      0,  23170,  23170,   1000,      0,      0, 0, 0, 0, 0, 0);
        add_row( 23170,      0,      0,  23170,      0, -32768,  32767, 0, 0, 0, 0, 0);
        add_row( 16384,  16384,  16384,  16384,  32767, -32768,  32767, 0, 0, 0, 0, 0);
        // Alternating bit patterns
        add_row( 21845, -21846,  21845, -21846, -21846,  21845, -21846, 0, 0, 0, 0, 0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (directed_rows[i])
        begin
            pace_sender();
            want = directed_rows[i].typed ? directed_rows[i].res
                                          : rotate_by_quat(directed_rows[i].req);
            send_rotation(directed_rows[i].req, want);
        end
        drain_results();

        // Random requests, with the occasional full drain
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i % DRAIN_EVERY == DRAIN_EVERY - 1)
                drain_results();
            pace_sender();
            req = random_request();
            send_rotation(req, rotate_by_quat(req));
        end
        start <= 1'b0;

        // Wait for the tail, then keep watching for any stray strobe
        while (pending_rotations.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
